// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each use clocks on clk and is held off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ppcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppcs_pkg;

  // Sine table over one turn; the depth must be a power of two, 256 to 4096
  localparam int SINE_DEPTH = 1024;
  localparam int ADDR_W     = $clog2(SINE_DEPTH);
  localparam int QN         = SINE_DEPTH / 4;
  localparam int QJ_W       = $clog2(QN + 1);

  // Angle gains in turns per radian, scaled by 2^18
  localparam logic signed [19:0] K_C10 = 20'sd417215;
  localparam logic signed [17:0] K_C2  = 18'sd83443;
  localparam logic signed [19:0] K_C8  = 20'sd333772;

  // Channel weights in Q0.16
  localparam logic signed [16:0] W_RED_A = 17'sd45875;
  localparam logic        [15:0] W_RED_P = 16'd19661;
  localparam logic signed [16:0] W_GRN_A = 17'sd55706;
  localparam logic        [15:0] W_GRN_P = 16'd9830;
  localparam logic signed [16:0] W_BLU_A = 17'sd49152;
  localparam logic        [15:0] W_BLU_P = 16'd16384;

  localparam logic [16:0] Q16_ONE  = 17'd65536;
  localparam logic [16:0] Q16_HALF = 17'd32768;
  localparam logic [15:0] SINE_PEAK = 16'd32768;

  // Taylor series constants for the quarter wave
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam int unsigned TAYLOR_DIV [6] = '{6, 20, 42, 72, 110, 156};

  typedef logic [QN:0][15:0] quarter_rom_t;

  typedef struct packed {
    logic            neg;
    logic [QJ_W-1:0] idx;
  } sine_addr_t;

  // Build the quarter-wave magnitudes, sin(pi/2 * j/QN) in Q1.15
  function automatic quarter_rom_t build_sine_rom();
    quarter_rom_t       rom;
    logic        [63:0] u30;
    logic        [63:0] x;
    logic        [63:0] x2;
    logic        [63:0] term;
    logic signed [63:0] sum;
    for (int j = 0; j <= QN; j++) begin
      u30  = (64'(4 * j) << 30) / SINE_DEPTH;
      x    = (u30 * HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      for (int k = 0; k < 6; k++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[k];
        if ((k % 2) == 0) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > signed'(Q30_ONE)) begin
        sum = signed'(Q30_ONE);
      end
      rom[j] = 16'((sum + 64'sd16384) >>> 15);
    end
    return rom;
  endfunction

  localparam quarter_rom_t SINE_ROM = build_sine_rom();

  // Fold a 16-bit angle onto the quarter wave
  function automatic sine_addr_t sine_addr(input logic [15:0] ang);
    logic [ADDR_W-1:0] full;
    logic [ADDR_W-3:0] low;
    sine_addr_t        a;
    full  = ang[15 -: ADDR_W];
    low   = full[ADDR_W-3:0];
    a.neg = full[ADDR_W-1];
    a.idx = full[ADDR_W-2] ? (QJ_W'(QN) - QJ_W'(low)) : QJ_W'(low);
    return a;
  endfunction

endpackage

`default_nettype wire

// File: rtl/procedural_pixel_color_shader.sv
`timescale 1ns / 1ps
`default_nettype none
// Procedural pixel colour shader.
// Input channel: in_valid / in_ready with one pixel per transfer (coordinates, noise,
// blended channels and vignette gain). Output channel: out_valid / out_ready with the
// three bytes of the shaded pixel.
// frame_phase is written through cfg_wr_en / cfg_wr_data; the user must write it only while
// no pixel is in flight, as the block itself does not enforce this.
// Pipeline: seven register stages (input, angle products, sine table read, weight products,
// clamp, vignette product, byte rounding) each hold one pixel.
// Throughput: one pixel per cycle while out_ready is high; a stage takes a new pixel
// whenever it is empty or the next stage advances.
// The sine table is a 257-entry quarter-wave ROM with two registered read ports, one
// for the stripe term and one for the blue cosine term.
// Stall: when out_ready is low, the stage holding a result keeps it and earlier stages
// keep filling any empty slots, so in_ready falls only once all seven stages are full.
// Reset: rst (synchronous) empties the pipeline and sets frame_phase to zero.
`include "assert_macros.svh"

module procedural_pixel_color_shader
  import ppcs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic        [15:0] cfg_wr_data,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic signed [15:0] coord_x,
  input  wire logic signed [15:0] coord_y,
  input  wire logic signed [15:0] noise_value,
  input  wire logic signed [15:0] blend_red,
  input  wire logic signed [15:0] blend_green,
  input  wire logic signed [15:0] blend_blue,
  input  wire logic        [15:0] vignette_gain,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic        [7:0]  red_byte,
  output      logic        [7:0]  green_byte,
  output      logic        [7:0]  blue_byte
);

  localparam int NSTG = 7;

  logic [15:0]     frame_phase;
  logic [NSTG:1]   vld;
  logic [NSTG+1:1] en;

  // Hold the frame phase
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_phase <= '0;
    end else if (cfg_wr_en) begin
      frame_phase <= cfg_wr_data;
    end
  end

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    en[NSTG+1] = out_ready;
    for (int k = NSTG; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld[NSTG];

  // Move valid bits along with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 1: register the pixel
  logic signed [15:0] x1, y1, n1, br1, bg1, bb1;
  logic        [15:0] vig1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x1   <= coord_x;
      y1   <= coord_y;
      n1   <= noise_value;
      br1  <= blend_red;
      bg1  <= blend_green;
      bb1  <= blend_blue;
      vig1 <= vignette_gain;
    end
  end

  // Stage 2: angle products, kept modulo 2^32
  logic signed [16:0] xy1;
  logic signed [36:0] ps_full;
  logic signed [33:0] pn_full;
  logic signed [35:0] pc_full;
  logic        [31:0] ps2, pn2, pc2;
  logic signed [15:0] br2, bg2, bb2;
  logic        [15:0] vig2;

  always_comb begin
    xy1     = {x1[15], x1} + {y1[15], y1};
    ps_full = xy1 * K_C10;
    pn_full = n1 * K_C2;
    pc_full = x1 * K_C8;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      ps2  <= ps_full[31:0];
      pn2  <= pn_full[31:0];
      pc2  <= pc_full[31:0];
      br2  <= br1;
      bg2  <= bg1;
      bb2  <= bb1;
      vig2 <= vig1;
    end
  end

  // Stage 3: round the angles and read the quarter-wave table
  logic [31:0] acc_s, acc_c;
  logic [15:0] ang_s, ang_c;
  sine_addr_t  sa_s, sa_c;
  logic [15:0] mag_s3, mag_c3;
  logic        neg_s3, neg_c3;
  logic signed [15:0] br3, bg3, bb3;
  logic        [15:0] vig3;

  always_comb begin
    acc_s = ps2 + pn2 + {frame_phase, 16'h0000} + 32'h0000_8000;
    acc_c = pc2 - {frame_phase, 16'h0000} + 32'h0000_8000;
    ang_s = acc_s[31:16];
    ang_c = acc_c[31:16] + 16'h4000;
    sa_s  = sine_addr(ang_s);
    sa_c  = sine_addr(ang_c);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      mag_s3 <= SINE_ROM[sa_s.idx];
      mag_c3 <= SINE_ROM[sa_c.idx];
      neg_s3 <= sa_s.neg;
      neg_c3 <= sa_c.neg;
      br3    <= br2;
      bg3    <= bg2;
      bb3    <= bb2;
      vig3   <= vig2;
    end
  end

  // Stage 4: pattern terms and weight products
  logic        [16:0] s16, c16, sg16;
  logic signed [32:0] mr_a4, mg_a4, mb_a4;
  logic        [32:0] mr_p4, mg_p4, mb_p4;
  logic        [15:0] vig4;

  always_comb begin
    s16  = neg_s3 ? (Q16_HALF - {1'b0, mag_s3}) : (Q16_HALF + {1'b0, mag_s3});
    c16  = neg_c3 ? (Q16_HALF - {1'b0, mag_c3}) : (Q16_HALF + {1'b0, mag_c3});
    sg16 = Q16_ONE - s16;
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      mr_a4 <= br3 * W_RED_A;
      mg_a4 <= bg3 * W_GRN_A;
      mb_a4 <= bb3 * W_BLU_A;
      mr_p4 <= s16 * W_RED_P;
      mg_p4 <= sg16 * W_GRN_P;
      mb_p4 <= c16 * W_BLU_P;
      vig4  <= vig3;
    end
  end

  // Stage 5: sum each channel in Q32 and clamp to 0..1
  function automatic logic [32:0] mix_clamp(input logic signed [32:0] pa,
                                            input logic        [32:0] pp);
    logic signed [35:0] sum;
    logic        [32:0] res;
    sum = {pa[32], pa, 2'b00} + {3'b000, pp};
    if (sum < 0) begin
      res = '0;
    end else if (sum > 36'sd4294967296) begin
      res = 33'h1_0000_0000;
    end else begin
      res = sum[32:0];
    end
    return res;
  endfunction

  logic [32:0] cr5, cg5, cb5;
  logic [15:0] vig5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      cr5  <= mix_clamp(mr_a4, mr_p4);
      cg5  <= mix_clamp(mg_a4, mg_p4);
      cb5  <= mix_clamp(mb_a4, mb_p4);
      vig5 <= vig4;
    end
  end

  // Stage 6: apply the vignette to red and green
  logic [48:0] r6, g6;
  logic [32:0] b6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      r6 <= cr5 * vig5;
      g6 <= cg5 * vig5;
      b6 <= cb5;
    end
  end

  // Stage 7: scale by 255, round half up and saturate
  logic [56:0] rt, gt;
  logic [40:0] bt;
  logic [7:0]  rb, gb, bbyte;

  always_comb begin
    rt    = ({8'd0, r6} << 8) - {8'd0, r6} + (57'd1 << 46);
    gt    = ({8'd0, g6} << 8) - {8'd0, g6} + (57'd1 << 46);
    bt    = ({8'd0, b6} << 8) - {8'd0, b6} + (41'd1 << 31);
    rb    = (rt[56:55] != 2'b00) ? 8'hFF : rt[54:47];
    gb    = (gt[56:55] != 2'b00) ? 8'hFF : gt[54:47];
    bbyte = bt[40] ? 8'hFF : bt[39:32];
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      red_byte   <= rb;
      green_byte <= gb;
      blue_byte  <= bbyte;
    end
  end

  // Checks on the pipeline control and the table
  `ASSERT_IMPL(a_ready_when_drained, !vld[NSTG], in_ready, "in_ready low with output empty")
  `ASSERT_NEXT(a_hold_on_stall, vld[6] && vld[7] && !out_ready, vld[6] && $stable(r6) && $stable(b6), "stage 6 lost data in stall")
  `ASSERT_IMPL(a_table_range, vld[3], (mag_s3 <= SINE_PEAK) && (mag_c3 <= SINE_PEAK), "sine table magnitude above one")

endmodule

`default_nettype wire

// File: dv/procedural_pixel_color_shader_tb.sv
`timescale 1ns / 1ps

module procedural_pixel_color_shader_tb;

  localparam int TAB_DEPTH = 1024;
  localparam int TAB_BITS  = 10;
  localparam longint K_STRIPE = 417215;   // 10/2pi turns, scaled by 2^18
  localparam longint K_NOISE  = 83443;    // 2/2pi
  localparam longint K_BAR    = 333772;   // 8/2pi
  localparam longint UNIT_Q32 = 64'sd4294967296;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint SINE_ONE_Q30 = 64'sd1073741824;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] noise;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] vignette;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               cfg_wr_en     = 1'b0;
  logic        [15:0] cfg_wr_data   = '0;
  logic               in_valid      = 1'b0;
  wire                in_ready;
  logic signed [15:0] coord_x       = '0;
  logic signed [15:0] coord_y       = '0;
  logic signed [15:0] noise_value   = '0;
  logic signed [15:0] blend_red     = '0;
  logic signed [15:0] blend_green   = '0;
  logic signed [15:0] blend_blue    = '0;
  logic        [15:0] vignette_gain = '0;
  wire                out_valid;
  logic               out_ready     = 1'b0;
  wire         [7:0]  red_byte;
  wire         [7:0]  green_byte;
  wire         [7:0]  blue_byte;

  pixel_t      pixel_queue [$];
  rgb_t        colour_queue [$];
  int          sine_tab [TAB_DEPTH];
  logic [15:0] phase_model = '0;
  int          pixels_loaded = 0;
  int          pixels_taken = 0;
  int          colours_checked = 0;
  int          mismatches = 0;
  int          quiet_left [2] = '{0, 0};
  int          in_gap = 0;
  int          out_stall = 0;
  int          out_draw = 0;
  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;

  procedural_pixel_color_shader u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .noise_value  (noise_value),
    .blend_red    (blend_red),
    .blend_green  (blend_green),
    .blend_blue   (blend_blue),
    .vignette_gain(vignette_gain),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .red_byte     (red_byte),
    .green_byte   (green_byte),
    .blue_byte    (blue_byte)
  );

  always #1 clk = ~clk;

  // Sine entry in Q1.15: quarter-wave fold, then a degree-13 Taylor series in Q30
  function automatic int sine_q15(input int i);
    longint unsigned q4, quad, r, u30, x, x2, term;
    longint          sum;
    longint          mag;
    q4   = longint'(i % TAB_DEPTH) * 4;
    quad = q4 / TAB_DEPTH;
    r    = q4 - quad * TAB_DEPTH;
    if (quad[0]) begin
      r = TAB_DEPTH - r;
    end
    u30  = (r << 30) / TAB_DEPTH;
    x    = (u30 * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > SINE_ONE_Q30) begin
      sum = SINE_ONE_Q30;
    end
    mag = (sum + 16384) >>> 15;
    return (quad >= 2) ? -int'(mag) : int'(mag);
  endfunction

  // Weighted sum of a Q2.14 channel and a Q0.16 pattern, in Q32, held to 0..1
  function automatic longint mix_sat(input longint chan, input longint w_chan,
                                     input longint pat, input longint w_pat);
    longint acc;
    acc = chan * 4 * w_chan + pat * w_pat;
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > UNIT_Q32) begin
      acc = UNIT_Q32;
    end
    return acc;
  endfunction

  // Round half up to a byte and saturate at 255
  function automatic logic [7:0] to_byte(input longint unsigned v, input int frac);
    longint unsigned b;
    b = (v * 255 + (64'd1 << (frac - 1))) >> frac;
    return (b > 255) ? 8'd255 : b[7:0];
  endfunction

  function automatic rgb_t shade_pixel(input pixel_t p, input logic [15:0] phase);
    longint          sx, sy, sn, sr, sg, sb, turn, acc, stripe, bar;
    longint unsigned vig;
    logic    [15:0]  ang_s, ang_c;
    rgb_t            c;
    sx   = $signed(p.x);
    sy   = $signed(p.y);
    sn   = $signed(p.noise);
    sr   = $signed(p.red);
    sg   = $signed(p.green);
    sb   = $signed(p.blue);
    vig  = p.vignette;
    turn = longint'(phase) << 16;
    // Angles round half up to 16-bit turns and wrap
    acc   = (sx + sy) * K_STRIPE + sn * K_NOISE + turn + 32768;
    ang_s = acc[31:16];
    acc   = sx * K_BAR - turn + 32768;
    ang_c = acc[31:16];
    ang_c = ang_c + 16'd16384;   // cosine is sine a quarter turn on
    stripe = 32768 + sine_tab[ang_s[15 -: TAB_BITS]];
    bar    = 32768 + sine_tab[ang_c[15 -: TAB_BITS]];
    c.red   = to_byte(longint'(mix_sat(sr, 45875, stripe, 19661)) * vig, 47);
    c.green = to_byte(longint'(mix_sat(sg, 55706, 65536 - stripe, 9830)) * vig, 47);
    c.blue  = to_byte(mix_sat(sb, 49152, bar, 16384), 32);
    return c;
  endfunction

  // Wait before the next transfer: mostly none or 0..16, with calm runs of no waiting
  function automatic int draw_wait(input int side);
    if (quiet_left[side] > 0) begin
      quiet_left[side] = quiet_left[side] - 1;
      return 0;
    end
    if ($urandom_range(0, 63) == 0) begin
      quiet_left[side] = 40;
      return 0;
    end
    if ($urandom_range(0, 1) == 0) begin
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  task automatic check_byte(input string chan, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, chan, want, got);
      mismatches++;
    end
  endtask

  task automatic load_pixel(input logic [15:0] x, input logic [15:0] y, input logic [15:0] n,
                            input logic [15:0] r, input logic [15:0] g, input logic [15:0] b,
                            input logic [15:0] v);
    pixel_queue.push_back({x, y, n, r, g, b, v});
    pixels_loaded++;
  endtask

  task automatic set_frame_phase(input logic [15:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    phase_model = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    while (!(pixels_taken == pixels_loaded && colours_checked == pixels_taken)) begin
      @(negedge clk);
    end
  endtask

  // Pixel driver: hold valid until the transfer, then idle or present the next pixel
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (pixel_queue.size() != 0) begin
        {coord_x, coord_y, noise_value, blend_red, blend_green, blend_blue,
         vignette_gain} <= pixel_queue.pop_front();
        in_valid <= 1'b1;
        in_gap   <= draw_wait(0);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result sink: stall for a drawn number of cycles after each transfer
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else if (out_fire) begin
      out_draw = draw_wait(1);
      out_ready <= (out_draw == 0);
      out_stall <= out_draw;
    end else if (out_stall > 0) begin
      out_ready <= (out_stall == 1);
      out_stall <= out_stall - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predict on each pixel transfer, check each colour transfer in order
  always @(posedge clk) begin
    if (rst) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire  <= in_valid && in_ready;
      out_fire <= out_valid && out_ready;
      if (in_valid && in_ready) begin
        colour_queue.push_back(shade_pixel({coord_x, coord_y, noise_value, blend_red,
                                            blend_green, blend_blue, vignette_gain},
                                           phase_model));
        pixels_taken <= pixels_taken + 1;
      end
      if (out_valid && out_ready) begin
        if (colour_queue.size() == 0) begin
          $display("%0t: unexpected colour, expected none, actual %0d %0d %0d",
                   $time, red_byte, green_byte, blue_byte);
          mismatches++;
        end else begin
          check_byte("red_byte", colour_queue[0].red, red_byte);
          check_byte("green_byte", colour_queue[0].green, green_byte);
          check_byte("blue_byte", colour_queue[0].blue, blue_byte);
          void'(colour_queue.pop_front());
          colours_checked <= colours_checked + 1;
        end
      end
    end
  end

  initial begin
    logic [15:0] phase_plan [7];
    logic [15:0] cx, cy, cn, cv;
    phase_plan = '{16'd0, 16'hFFFF, 16'd32768, 16'd16384, 16'd1,
                   16'($urandom), 16'($urandom)};
    for (int i = 0; i < TAB_DEPTH; i++) begin
      sine_tab[i] = sine_q15(i);
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 7; ph++) begin
      set_frame_phase(phase_plan[ph]);
      if (ph == 0) begin
        // Extremes of every field, wrapped angles and vignette past one
        load_pixel(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd32768);
        load_pixel(-16'sd16384, -16'sd16384, -16'sd16384, 16'h8000, 16'h8000, 16'h8000,
                   16'd0);
        load_pixel(16'd16384, 16'd16384, 16'd16384, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd32768);
        load_pixel(16'd16384, -16'sd16384, 16'd0, 16'd16384, 16'd16384, 16'd16384,
                   16'd32768);
        load_pixel(16'd0, 16'd0, 16'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        load_pixel(16'd8192, 16'd0, 16'd0, 16'd8192, 16'd8192, 16'd8192, 16'hFFFF);
        load_pixel(16'h8000, 16'h7FFF, 16'h8000, 16'd0, 16'd0, 16'd0, 16'd32768);
        load_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hC000, 16'h4000, 16'hC000, 16'h8001);
        load_pixel(16'd4096, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd32768);
        load_pixel(-16'sd4096, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd32768);
        load_pixel(16'd12288, 16'd4096, 16'd0, 16'h4000, 16'h0000, 16'hC000, 16'd16384);
        load_pixel(16'd0, 16'd0, 16'd16384, 16'd0, 16'd16384, 16'd0, 16'd32768);
        load_pixel(16'd0, 16'd0, -16'sd16384, 16'd16384, 16'd0, 16'd16384, 16'd32768);
        load_pixel(-16'sd16384, 16'd16384, 16'd8192, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
        load_pixel(16'd1, 16'hFFFF, 16'd1, 16'd1, 16'd1, 16'd1, 16'h7FFF);
        load_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        load_pixel(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        load_pixel(16'd16384, 16'd16384, -16'sd16384, 16'd12000, 16'd12000, 16'd12000,
                   16'd32768);
      end
      // Random pixels, mostly in range, some with any bit pattern
      for (int i = 0; i < 200; i++) begin
        cx = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                         : 16'($urandom_range(0, 32768)) - 16'd16384;
        cy = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                         : 16'($urandom_range(0, 32768)) - 16'd16384;
        cn = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                         : 16'($urandom_range(0, 32768)) - 16'd16384;
        cv = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
        load_pixel(cx, cy, cn, 16'($urandom), 16'($urandom), 16'($urandom), cv);
      end
      wait_drained();
    end

    // Let any stray colour surface before the verdict
    repeat (12) @(negedge clk);
    if (colour_queue.size() != 0) begin
      $display("%0t: %0d colours expected, actual none", $time, colour_queue.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: procedural_pixel_color_shader.f
+incdir+rtl
rtl/ppcs_pkg.sv
rtl/procedural_pixel_color_shader.sv
dv/procedural_pixel_color_shader_tb.sv
